// File: src/bbcl_pkg.sv
// Package for the barycentric bin change locator.
// Field widths, fixed-point constants, register codes and the controller state type.
// No dependencies.
`default_nettype none

package bbcl_pkg;

  // field widths
  localparam int DELAY_W   = 40;  // signed Q24.16 delay
  localparam int BPS_W     = 40;  // unsigned Q24.16 step length
  localparam int SLEN_W    = 23;  // series length
  localparam int BIN_W     = 24;  // signed bin position
  localparam int FRAC_BITS = 16;  // Q16 fraction bits

  // limits
  localparam int MAX_PER_SAMPLE = 16;
  localparam int MAX_STEPS      = 65536;

  // derived widths
  localparam int STEP_W = $clog2(MAX_STEPS);
  localparam int CNT_W  = $clog2(MAX_PER_SAMPLE + 1);
  localparam int IDX_W  = (MAX_PER_SAMPLE > 1) ? $clog2(MAX_PER_SAMPLE) : 1;
  localparam int CP_W   = DELAY_W + 2;      // crossing point, signed
  localparam int DIFF_W = DELAY_W + 3;      // interpolation differences, signed
  localparam int QF_W   = 32;               // divider quotient bits
  localparam int ITER_W = $clog2(QF_W);     // shared iteration counter
  localparam int LO_W   = BPS_W + STEP_W;   // step start position, Q16
  localparam int SUM_W  = LO_W + 1;         // step start plus offset
  localparam int RQ_W   = SUM_W - FRAC_BITS;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LENGTH = 1'b1;

  // reset values and constants
  localparam logic [BPS_W-1:0]     BPS_RESET  = BPS_W'(65536);
  localparam logic [SLEN_W-1:0]    SLEN_RESET = SLEN_W'(8388607);
  localparam logic [BIN_W-1:0]     BIN_MAX    = BIN_W'(8388607);
  localparam logic [FRAC_BITS-1:0] HALF_FRAC  = {1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [CP_W-1:0]      HALF_CP    = CP_W'(32768);
  localparam logic [CP_W-1:0]      ONE_CP     = CP_W'(65536);

  // controller states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ABS   = 12'b0000_0000_0010,
    S_ROUND = 12'b0000_0000_0100,
    S_LO    = 12'b0000_0000_1000,
    S_CHECK = 12'b0000_0001_0000,
    S_PREP  = 12'b0000_0010_0000,
    S_DCHK  = 12'b0000_0100_0000,
    S_DIV   = 12'b0000_1000_0000,
    S_SCALE = 12'b0001_0000_0000,
    S_SUM   = 12'b0010_0000_0000,
    S_RND   = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

// File: src/barycentric_bin_change_locator.sv
// Top level of the barycentric bin change locator; depends on bbcl_pkg.
// Steps: a first-sample or same-bin beat ends after rounding. A bin change runs the bit-serial
//   step multiply, then per interpolated crossing the divider and the scaler (both skipped when
//   the fraction is zero or one); once stopped, crossings are only walked. Then the results leave.
// Throughput: one input beat at a time; the next is taken once the last result has moved
//   into the output register. Reset (rst, synchronous): defaults, state cleared, none pending.
`default_nettype none

module barycentric_bin_change_locator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [bbcl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbcl_pkg::BPS_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bbcl_pkg::DELAY_W-1:0]   delay_bins,
  input  logic                                  first_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bbcl_pkg::BIN_W-1:0]     bin_position,
  output logic                                  last_of_step,
  output logic                                  crossings_dropped
);

  localparam int DELAY_W   = bbcl_pkg::DELAY_W;
  localparam int BPS_W     = bbcl_pkg::BPS_W;
  localparam int SLEN_W    = bbcl_pkg::SLEN_W;
  localparam int BIN_W     = bbcl_pkg::BIN_W;
  localparam int FRAC_BITS = bbcl_pkg::FRAC_BITS;
  localparam int STEP_W    = bbcl_pkg::STEP_W;
  localparam int CNT_W     = bbcl_pkg::CNT_W;
  localparam int IDX_W     = bbcl_pkg::IDX_W;
  localparam int CP_W      = bbcl_pkg::CP_W;
  localparam int DIFF_W    = bbcl_pkg::DIFF_W;
  localparam int QF_W      = bbcl_pkg::QF_W;
  localparam int ITER_W    = bbcl_pkg::ITER_W;
  localparam int LO_W      = bbcl_pkg::LO_W;
  localparam int SUM_W     = bbcl_pkg::SUM_W;
  localparam int RQ_W      = bbcl_pkg::RQ_W;
  localparam int MAX_LEN   = bbcl_pkg::MAX_PER_SAMPLE;

  bbcl_pkg::state_t state, state_next;

  // configuration and series state
  logic [BPS_W-1:0]   bps;
  logic [SLEN_W-1:0]  slen;
  logic [DELAY_W-1:0] prev_delay;
  logic [BIN_W-1:0]   last_bin;
  logic [STEP_W-1:0]  step_idx;
  logic               stopped;

  // control counters
  logic [ITER_W-1:0]  cnt;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd;

  // datapath registers
  logic [DELAY_W-1:0] d_reg;
  logic               first_reg;
  logic [DELAY_W-1:0] absd;
  logic               up;
  logic               dropped;
  logic [CP_W-1:0]    cp;
  logic [STEP_W-1:0]  mop;
  logic [LO_W-1:0]    lo;
  logic [DIFF_W-1:0]  num;
  logic [DIFF_W-1:0]  den;
  logic [DIFF_W-1:0]  un;
  logic [DIFF_W-1:0]  ud;
  logic               f_zero;
  logic [DIFF_W-1:0]  rem;
  logic [QF_W-1:0]    fq;
  logic [BPS_W-1:0]   acc;
  logic [SUM_W-1:0]   msum;
  logic [BIN_W-1:0]   pos_buf [MAX_LEN];

  // ---------------------------------------------------------------
  // rounding of the incoming delay to a bin, ties to even, saturated
  logic [BIN_W-1:0]     rq;
  logic [FRAC_BITS-1:0] rr;
  logic                 r_up;
  logic [BIN_W:0]       rq_inc;
  logic [BIN_W-1:0]     rmag;
  logic [BIN_W-1:0]     cur_bin;
  logic                 up_w;
  logic [CP_W-1:0]      cp_base;
  logic [CP_W-1:0]      cp_init;
  logic [STEP_W-1:0]    step_sat;

  assign rq      = absd[DELAY_W-1:FRAC_BITS];
  assign rr      = absd[FRAC_BITS-1:0];
  assign r_up    = (rr > bbcl_pkg::HALF_FRAC) || ((rr == bbcl_pkg::HALF_FRAC) && rq[0]);
  assign rq_inc  = {1'b0, rq} + (BIN_W+1)'(r_up);
  assign rmag    = (rq_inc > {1'b0, bbcl_pkg::BIN_MAX}) ? bbcl_pkg::BIN_MAX
                                                          : rq_inc[BIN_W-1:0];
  assign cur_bin = d_reg[DELAY_W-1] ? (BIN_W'(0) - rmag) : rmag;
  assign up_w    = !cur_bin[BIN_W-1] && (cur_bin != '0);

  // first crossing: old bin plus or minus one half
  assign cp_base = {{(CP_W-BIN_W-FRAC_BITS){last_bin[BIN_W-1]}}, last_bin,
                    {FRAC_BITS{1'b0}}};
  assign cp_init = up_w ? (cp_base + bbcl_pkg::HALF_CP) : (cp_base - bbcl_pkg::HALF_CP);

  assign step_sat = (step_idx < STEP_W'(bbcl_pkg::MAX_STEPS - 1)) ? (step_idx + 1'b1)
                                                                   : step_idx;

  // ---------------------------------------------------------------
  // crossing walk: end test and interpolation differences
  logic [CP_W-1:0]   acp;
  logic              cross_done;
  logic              k_full;
  logic              walk_exit;
  logic [CP_W-1:0]   cp_step;
  logic [DIFF_W-1:0] prev_ext;
  logic [DIFF_W-1:0] num_w;
  logic [DIFF_W-1:0] den_w;

  assign acp        = cp[CP_W-1] ? (CP_W'(0) - cp) : cp;
  assign cross_done = acp >= {{(CP_W-DELAY_W){1'b0}}, absd};
  assign k_full     = (k == CNT_W'(MAX_LEN));
  assign walk_exit  = cross_done || k_full;
  assign cp_step    = up ? bbcl_pkg::ONE_CP : (CP_W'(0) - bbcl_pkg::ONE_CP);
  assign prev_ext   = {{(DIFF_W-DELAY_W){prev_delay[DELAY_W-1]}}, prev_delay};
  assign num_w      = {{(DIFF_W-CP_W){cp[CP_W-1]}}, cp} - prev_ext;
  assign den_w      = {{(DIFF_W-DELAY_W){d_reg[DELAY_W-1]}}, d_reg} - prev_ext;

  // ---------------------------------------------------------------
  // restoring divider step, one quotient bit a cycle
  logic [DIFF_W:0] rsh;
  logic [DIFF_W:0] dsub;
  logic            q_bit;

  assign rsh   = {rem, 1'b0};
  assign dsub  = rsh - {1'b0, ud};
  assign q_bit = rsh >= {1'b0, ud};

  // bit-serial scaler step, LSB of the fraction first
  logic [BPS_W:0] ssum;
  assign ssum = {1'b0, acc} + {1'b0, (fq[0] ? bps : BPS_W'(0))};

  // bit-serial step start multiply, MSB of the step count first
  logic [LO_W-1:0] lo_add;
  assign lo_add = {lo[LO_W-2:0], 1'b0}
                + (mop[STEP_W-1] ? {{STEP_W{1'b0}}, bps} : LO_W'(0));

  // ---------------------------------------------------------------
  // position rounding and series length test
  logic [RQ_W-1:0]      mq;
  logic [FRAC_BITS-1:0] mr;
  logic                 m_up;
  logic [RQ_W:0]        mmag;
  logic                 stop_hit;
  logic [BIN_W-1:0]     mlow;
  logic [BIN_W-1:0]     pos_w;

  assign mq       = msum[SUM_W-1:FRAC_BITS];
  assign mr       = msum[FRAC_BITS-1:0];
  assign m_up     = (mr > bbcl_pkg::HALF_FRAC) || ((mr == bbcl_pkg::HALF_FRAC) && mq[0]);
  assign mmag     = {1'b0, mq} + (RQ_W+1)'(m_up);
  assign stop_hit = mmag >= (RQ_W+1)'(slen);
  assign mlow     = mmag[BIN_W-1:0];
  assign pos_w    = up ? mlow : (BIN_W'(0) - mlow);

  // ---------------------------------------------------------------
  // output handshake
  logic load_out;
  logic rd_last;

  assign in_ready = (state == bbcl_pkg::S_IDLE);
  assign load_out = (state == bbcl_pkg::S_EMIT) && (!out_valid || out_ready);
  assign rd_last  = (rd == (count - 1'b1));

  // ---------------------------------------------------------------
  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbcl_pkg::S_IDLE: begin
        if (in_valid) state_next = bbcl_pkg::S_ABS;
      end
      bbcl_pkg::S_ABS: state_next = bbcl_pkg::S_ROUND;
      bbcl_pkg::S_ROUND: begin
        if (first_reg || (cur_bin == last_bin)) state_next = bbcl_pkg::S_IDLE;
        else state_next = bbcl_pkg::S_LO;
      end
      bbcl_pkg::S_LO: begin
        if (cnt == ITER_W'(STEP_W - 1)) state_next = bbcl_pkg::S_CHECK;
      end
      bbcl_pkg::S_CHECK: begin
        if (walk_exit) begin
          state_next = (count == '0) ? bbcl_pkg::S_IDLE : bbcl_pkg::S_EMIT;
        end else if (!stopped) begin
          state_next = bbcl_pkg::S_PREP;
        end
      end
      bbcl_pkg::S_PREP: state_next = bbcl_pkg::S_DCHK;
      bbcl_pkg::S_DCHK: begin
        if (f_zero || (un >= ud)) state_next = bbcl_pkg::S_SUM;
        else state_next = bbcl_pkg::S_DIV;
      end
      bbcl_pkg::S_DIV: begin
        if (cnt == ITER_W'(QF_W - 1)) state_next = bbcl_pkg::S_SCALE;
      end
      bbcl_pkg::S_SCALE: begin
        if (cnt == ITER_W'(QF_W - 1)) state_next = bbcl_pkg::S_SUM;
      end
      bbcl_pkg::S_SUM: state_next = bbcl_pkg::S_RND;
      bbcl_pkg::S_RND: state_next = bbcl_pkg::S_CHECK;
      bbcl_pkg::S_EMIT: begin
        if (load_out && rd_last) state_next = bbcl_pkg::S_IDLE;
      end
      default: state_next = bbcl_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // control state, configuration and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bbcl_pkg::S_IDLE;
      bps        <= bbcl_pkg::BPS_RESET;
      slen       <= bbcl_pkg::SLEN_RESET;
      prev_delay <= '0;
      last_bin   <= '0;
      step_idx   <= '0;
      stopped    <= 1'b0;
      cnt        <= '0;
      k          <= '0;
      count      <= '0;
      rd         <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_write_en) begin
        unique case (cfg_index)
          bbcl_pkg::CFG_BINS_PER_STEP: bps  <= cfg_data;
          bbcl_pkg::CFG_SERIES_LENGTH: slen <= cfg_data[SLEN_W-1:0];
        endcase
      end

      unique case (state)
        bbcl_pkg::S_ROUND: begin
          if (first_reg) begin
            prev_delay <= d_reg;
            last_bin   <= cur_bin;
            step_idx   <= '0;
            stopped    <= 1'b0;
          end else begin
            step_idx <= step_sat;
            last_bin <= cur_bin;
            if (cur_bin == last_bin) prev_delay <= d_reg;
          end
          cnt   <= '0;
          k     <= '0;
          count <= '0;
        end
        bbcl_pkg::S_LO: cnt <= cnt + 1'b1;
        bbcl_pkg::S_CHECK: begin
          if (walk_exit) begin
            prev_delay <= d_reg;
            rd         <= '0;
          end else if (stopped) begin
            k <= k + 1'b1;
          end
        end
        bbcl_pkg::S_DCHK: cnt <= '0;
        bbcl_pkg::S_DIV:   cnt <= cnt + 1'b1;
        bbcl_pkg::S_SCALE: cnt <= cnt + 1'b1;
        bbcl_pkg::S_RND: begin
          k <= k + 1'b1;
          if (stop_hit) stopped <= 1'b1;
          else count <= count + 1'b1;
        end
        bbcl_pkg::S_EMIT: begin
          if (load_out) rd <= rd + 1'b1;
        end
        default: ;
      endcase

      // output register valid
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bbcl_pkg::S_IDLE: begin
        d_reg     <= delay_bins;
        first_reg <= first_sample;
      end
      bbcl_pkg::S_ABS: begin
        absd <= d_reg[DELAY_W-1] ? (DELAY_W'(0) - d_reg) : d_reg;
      end
      bbcl_pkg::S_ROUND: begin
        up      <= up_w;
        cp      <= cp_init;
        dropped <= 1'b0;
        mop     <= step_sat - 1'b1;
        lo      <= '0;
      end
      bbcl_pkg::S_LO: begin
        lo  <= lo_add;
        mop <= {mop[STEP_W-2:0], 1'b0};
      end
      bbcl_pkg::S_CHECK: begin
        if (!cross_done && k_full) dropped <= 1'b1;
        if (!walk_exit && stopped) cp <= cp + cp_step;
        num <= num_w;
        den <= den_w;
      end
      bbcl_pkg::S_PREP: begin
        f_zero <= (num == '0) || (den == '0) || (num[DIFF_W-1] != den[DIFF_W-1]);
        un     <= num[DIFF_W-1] ? (DIFF_W'(0) - num) : num;
        ud     <= den[DIFF_W-1] ? (DIFF_W'(0) - den) : den;
      end
      bbcl_pkg::S_DCHK: begin
        rem <= un;
        if (f_zero) acc <= '0;
        else if (un >= ud) acc <= bps;
      end
      bbcl_pkg::S_DIV: begin
        rem <= q_bit ? dsub[DIFF_W-1:0] : rsh[DIFF_W-1:0];
        fq  <= {fq[QF_W-2:0], q_bit};
        acc <= '0;
      end
      bbcl_pkg::S_SCALE: begin
        acc <= ssum[BPS_W:1];
        fq  <= {1'b0, fq[QF_W-1:1]};
      end
      bbcl_pkg::S_SUM: begin
        msum <= {1'b0, lo} + {{(SUM_W-BPS_W){1'b0}}, acc};
      end
      bbcl_pkg::S_RND: begin
        if (!stop_hit) pos_buf[count[IDX_W-1:0]] <= pos_w;
        cp <= cp + cp_step;
      end
      bbcl_pkg::S_EMIT: begin
        if (load_out) begin
          bin_position      <= pos_buf[rd[IDX_W-1:0]];
          last_of_step      <= rd_last;
          crossings_dropped <= dropped;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/bbcl_checker.sv
// Port-level checker for the barycentric bin change locator, bound to the top level.
// Depends on bbcl_pkg.
`default_nettype none

module bbcl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bbcl_pkg::BIN_W-1:0]   bin_position,
  input logic                                last_of_step,
  input logic                                crossings_dropped
);

  localparam logic [bbcl_pkg::BIN_W-1:0] BIN_MIN = {1'b1, {(bbcl_pkg::BIN_W-1){1'b0}}};

  // reset leaves nothing pending and the input side open
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("result pending or input closed after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(bin_position)
                                   && $stable(last_of_step) && $stable(crossings_dropped)))
    else $error("stalled result beat changed");

  // one beat at a time: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // positions stay below the series length, so the most negative code never shows
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_position != BIN_MIN))
    else $error("bin position out of range");

endmodule

bind barycentric_bin_change_locator bbcl_checker u_bbcl_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for barycentric_bin_change_locator.
// Directed table, then random delay series over four handshake phases, checked by a local predictor.
// Depends on bbcl_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int DELAY_W        = bbcl_pkg::DELAY_W;
  localparam int BPS_W          = bbcl_pkg::BPS_W;
  localparam int SLEN_W         = bbcl_pkg::SLEN_W;
  localparam int BIN_W          = bbcl_pkg::BIN_W;
  localparam int FRAC_BITS      = bbcl_pkg::FRAC_BITS;
  localparam int CFG_IDX_W      = bbcl_pkg::CFG_IDX_W;
  localparam int MAX_PER_SAMPLE = bbcl_pkg::MAX_PER_SAMPLE;
  localparam int MAX_STEPS      = bbcl_pkg::MAX_STEPS;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 1300;       // worst single-beat latency with margin
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int BEATS_PER_PHASE = 75;

  localparam longint BIN_ONE  = 64'sd65536;
  localparam longint BIN_HALF = 64'sd32768;
  localparam longint unsigned UNITY_Q32 = 64'd1 << 32;

  typedef struct {
    logic signed [BIN_W-1:0] bin_position;
    logic                    last_of_step;
    logic                    crossings_dropped;
  } crossing_t;

  typedef enum {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic signed [DELAY_W-1:0] delay;
    logic                    first;
    int                      typed_count;  // -1: results come from the predictor
    logic signed [BIN_W-1:0] typed_pos;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [BPS_W-1:0]        reg_value;
  } stim_row_t;

  // DUT connections
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BPS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DELAY_W-1:0] delay_bins = '0;
  logic first_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [BIN_W-1:0] bin_position;
  logic last_of_step;
  logic crossings_dropped;

  barycentric_bin_change_locator i_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of registers and state
  logic [BPS_W-1:0]  model_bps  = bbcl_pkg::BPS_RESET;
  logic [SLEN_W-1:0] model_slen = bbcl_pkg::SLEN_RESET;
  longint      prev_delay_q16 = 0;
  longint      last_bin       = 0;
  int unsigned step_count     = 0;
  bit          stopped        = 1'b0;

  crossing_t expected_positions[$];
  crossing_t step_positions[$];
  int unsigned mismatches = 0;
  int unsigned beats_accepted = 0;
  int unsigned cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Q16 magnitude to integer, ties to even
  function automatic longint unsigned round_q16(input longint unsigned m);
    longint unsigned q;
    q = m >> FRAC_BITS;
    if (m[FRAC_BITS-1:0] > bbcl_pkg::HALF_FRAC ||
        (m[FRAC_BITS-1:0] == bbcl_pkg::HALF_FRAC && q[0]))
      q++;
    return q;
  endfunction

  // signed Q16 delay to bin, magnitude saturated
  function automatic longint round_to_bin(input longint x);
    longint unsigned m;
    longint q;
    m = (x < 0) ? -x : x;
    q = round_q16(m);
    if (q > longint'(bbcl_pkg::BIN_MAX))
      q = longint'(bbcl_pkg::BIN_MAX);
    return (x < 0) ? -q : q;
  endfunction

  // Advance the predictor by one input beat; fills step_positions.
  function automatic void locate_crossings(input logic signed [DELAY_W-1:0] delay,
                                           input logic first);
    longint d, cur, cp, num, den;
    longint unsigned absd, acp, lo, un, ud, frac, rem, scaled, mag, pos;
    bit up, dropped, done;
    int k;
    step_positions.delete();
    d = longint'(delay);
    dropped = 1'b0;
    if (first) begin
      prev_delay_q16 = d;
      last_bin = round_to_bin(d);
      step_count = 0;
      stopped = 1'b0;
      return;
    end
    if (step_count < MAX_STEPS - 1)
      step_count++;
    cur = round_to_bin(d);
    if (cur != last_bin) begin
      up = cur > 0;
      cp = last_bin * BIN_ONE + (up ? BIN_HALF : -BIN_HALF);
      absd = (d < 0) ? -d : d;
      lo = (step_count - 1) * model_bps;
      k = 0;
      done = 1'b0;
      // walk half-bin crossings toward the new delay
      while (!done) begin
        acp = (cp < 0) ? -cp : cp;
        if (acp >= absd) begin
          done = 1'b1;
        end else if (k == MAX_PER_SAMPLE) begin
          dropped = 1'b1;
          done = 1'b1;
        end else begin
          if (!stopped) begin
            num = cp - prev_delay_q16;
            den = d - prev_delay_q16;
            frac = 0;
            if (num != 0 && den != 0 && ((num < 0) == (den < 0))) begin
              un = (num < 0) ? -num : num;
              ud = (den < 0) ? -den : den;
              if (un >= ud) begin
                frac = UNITY_Q32;
              end else begin
                // restoring division, 32 fraction bits
                rem = un;
                for (int b = 0; b < 32; b++) begin
                  rem = rem << 1;
                  frac = frac << 1;
                  if (rem >= ud) begin
                    rem = rem - ud;
                    frac = frac | 64'd1;
                  end
                end
              end
            end
            if (frac == UNITY_Q32)
              scaled = model_bps;
            else
              scaled = frac * model_bps[BPS_W-1:32] + ((frac * model_bps[31:0]) >> 32);
            mag = round_q16(lo + scaled);
            if (mag >= model_slen) begin
              stopped = 1'b1;
            end else begin
              pos = up ? mag : (64'd0 - mag);
              step_positions.push_back('{bin_position: pos[BIN_W-1:0],
                                         last_of_step: 1'b0, crossings_dropped: 1'b0});
            end
          end
          cp = cp + (up ? BIN_ONE : -BIN_ONE);
          k++;
        end
      end
      last_bin = cur;
    end
    prev_delay_q16 = d;
    foreach (step_positions[j]) begin
      step_positions[j].crossings_dropped = dropped;
      step_positions[j].last_of_step = (j == step_positions.size() - 1);
    end
  endfunction

  function automatic stim_row_t beat_row(input logic signed [DELAY_W-1:0] delay,
                                         input logic first, input int typed_count,
                                         input logic signed [BIN_W-1:0] typed_pos);
    stim_row_t row;
    row = '{kind: ROW_BEAT, delay: delay, first: first, typed_count: typed_count,
            typed_pos: typed_pos, reg_index: '0, reg_value: '0};
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [BPS_W-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_WRITE, delay: '0, first: 1'b0, typed_count: 0,
            typed_pos: '0, reg_index: index, reg_value: value};
    return row;
  endfunction

  // Present one beat after random idle cycles; queue its results once accepted.
  task automatic send_beat(input stim_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    delay_bins   <= row.delay;
    first_sample <= row.first;
    do @(posedge clk); while (!in_ready);
    beats_accepted++;
    locate_crossings(row.delay, row.first);
    if (row.typed_count >= 0) begin
      repeat (row.typed_count)
        expected_positions.push_back('{bin_position: row.typed_pos, last_of_step: 1'b1,
                                       crossings_dropped: 1'b0});
    end else begin
      foreach (step_positions[j])
        expected_positions.push_back(step_positions[j]);
    end
  endtask

  // Stop sending, wait out every expected result and any silent work in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_positions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [BPS_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (index == bbcl_pkg::CFG_BINS_PER_STEP)
      model_bps = value;
    else
      model_slen = value[SLEN_W-1:0];
  endtask

  // result side: check each accepted beat, stall at random
  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result: bin_position %0d", bin_position);
          mismatches++;
        end else begin
          want = expected_positions.pop_front();
          if (bin_position !== want.bin_position) begin
            $error("bin_position: expected %0d, got %0d", want.bin_position, bin_position);
            mismatches++;
          end
          if (last_of_step !== want.last_of_step) begin
            $error("last_of_step: expected %0d, got %0d", want.last_of_step, last_of_step);
            mismatches++;
          end
          if (crossings_dropped !== want.crossings_dropped) begin
            $error("crossings_dropped: expected %0d, got %0d",
                   want.crossings_dropped, crossings_dropped);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    int unsigned phase_target;
    int series_steps;
    longint track, delta;
    logic [63:0] wide;

    // Directed table. Typed counts hold where the outcome is plain; -1 uses the predictor.
    directed_rows = '{
      // no first beat after reset: acts as a zero start, one crossing at bin 0
      beat_row(40'sh00_0001_0000, 1'b0, 1, '0),
      beat_row(40'sh00_0001_0000, 1'b1, 0, '0),
      beat_row(40'sh00_0001_0000, 1'b0, 0, '0),     // same bin, nothing
      beat_row(40'sh00_0000_8000, 1'b1, 0, '0),     // 0.5 rounds to 0
      beat_row(40'sh00_0001_0000, 1'b0, 1, '0),     // crossing equals previous: zero span
      beat_row(40'sh00_0001_8000, 1'b0, 0, '0),     // 1.5 rounds to 2, crossing not below
      beat_row(40'sh00_0014_0000, 1'b0, -1, '0),    // 18 crossings, extras dropped
      beat_row(-40'sh00_0019_8000, 1'b0, -1, '0),   // downward walk, also dropped
      write_row(bbcl_pkg::CFG_BINS_PER_STEP, '0),
      beat_row(40'sh00_0000_0000, 1'b1, 0, '0),
      beat_row(-40'sh00_0005_0000, 1'b0, -1, '0),   // downward, zero step length
      write_row(bbcl_pkg::CFG_BINS_PER_STEP, {BPS_W{1'b1}}),
      beat_row(40'sh00_0005_0000, 1'b0, -1, '0),    // huge step length stops output
      write_row(bbcl_pkg::CFG_BINS_PER_STEP, BPS_W'(196608)),
      write_row(bbcl_pkg::CFG_SERIES_LENGTH, BPS_W'(4)),
      beat_row(40'sh00_0000_0000, 1'b1, 0, '0),
      beat_row(40'sh00_000A_0000, 1'b0, -1, '0),
      beat_row(40'sh00_000C_0000, 1'b0, -1, '0),    // reaches series length here
      beat_row(40'sh00_000E_0000, 1'b0, 0, '0),     // stays stopped
      write_row(bbcl_pkg::CFG_SERIES_LENGTH, BPS_W'(0)),
      beat_row(40'sh7F_FFFF_FFFF, 1'b1, 0, '0),     // bin saturates
      beat_row(40'sh80_0000_0000, 1'b0, 0, '0)      // zero length suppresses all
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct    = 13;
    receiver_stall_pct = 13;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain();
        write_register(directed_rows[r].reg_index, directed_rows[r].reg_value);
      end else begin
        send_beat(directed_rows[r]);
      end
    end

    // random phases: settings and handshake pressure change per phase
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          sender_idle_pct = 0;  receiver_stall_pct = 0;
          write_register(bbcl_pkg::CFG_BINS_PER_STEP,
                         BPS_W'(65536 * $urandom_range(1, 4)));
          write_register(bbcl_pkg::CFG_SERIES_LENGTH, BPS_W'(bbcl_pkg::SLEN_RESET));
        end
        1: begin
          sender_idle_pct = 65; receiver_stall_pct = 0;
          write_register(bbcl_pkg::CFG_BINS_PER_STEP, BPS_W'($urandom_range(1, 1 << 22)));
          write_register(bbcl_pkg::CFG_SERIES_LENGTH,
                         BPS_W'($urandom_range(1000, 8388607)));
        end
        2: begin
          sender_idle_pct = 0;  receiver_stall_pct = 65;
          write_register(bbcl_pkg::CFG_BINS_PER_STEP, BPS_W'($urandom_range(0, 1 << 20)));
          write_register(bbcl_pkg::CFG_SERIES_LENGTH, BPS_W'($urandom_range(20, 400)));
        end
        default: begin
          sender_idle_pct = 13; receiver_stall_pct = 13;
          wide = {$urandom, $urandom};
          wide = wide >> $urandom_range(24, 48);
          write_register(bbcl_pkg::CFG_BINS_PER_STEP, wide[BPS_W-1:0]);
          write_register(bbcl_pkg::CFG_SERIES_LENGTH, BPS_W'($urandom_range(1, 8388607)));
        end
      endcase

      phase_target = beats_accepted + BEATS_PER_PHASE;
      while (beats_accepted < phase_target) begin
        if ($urandom_range(99) < 15) begin
          // noise: any delay, any start flag
          wide = {$urandom, $urandom};
          send_beat(beat_row(wide[DELAY_W-1:0], 1'($urandom_range(1)), -1, '0));
        end else begin
          // a series: start beat then a drifting delay
          if ($urandom_range(9) == 0) begin
            wide = {$urandom, $urandom};
            track = longint'($signed(wide[DELAY_W-1:0]));
          end else begin
            track = longint'($urandom_range(0, 32'd262144000)) - 64'sd131072000;
          end
          send_beat(beat_row(track[DELAY_W-1:0], 1'b1, -1, '0));
          series_steps = $urandom_range(4, 24);
          repeat (series_steps) begin
            case ($urandom_range(19))
              0, 1:    delta = longint'($urandom_range(0, 80 * 65536)) - 40 * 65536;
              2:       delta = (longint'($urandom_range(0, 16)) - 8) * BIN_HALF;
              default: delta = longint'($urandom_range(0, 12 * 65536)) - 6 * 65536;
            endcase
            track = track + delta;
            track = {{(64 - DELAY_W){track[DELAY_W-1]}}, track[DELAY_W-1:0]};
            send_beat(beat_row(track[DELAY_W-1:0], 1'b0, -1, '0));
          end
        end
      end
    end

    drain();
    if (mismatches == 0 && expected_positions.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// File: files.f
src/bbcl_pkg.sv
src/barycentric_bin_change_locator.sv
src/bbcl_checker.sv
tb/testbench.sv
